// ----- design/sorted_table_search_engine_macros.svh -----
// Assertion macros shared by the search engine modules.
`ifndef SORTED_TABLE_SEARCH_ENGINE_MACROS_SVH
`define SORTED_TABLE_SEARCH_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
`define STSE_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define STSE_ASSERT_NEXT(name, clk, rst_n, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define STSE_ASSERT(name, clk, rst_n, prop)
`define STSE_ASSERT_NEXT(name, clk, rst_n, cond, expr)
`endif

`endif

// ----- design/stse_pkg.sv -----
`default_nettype none
package stse_pkg;

    localparam int KEY_W       = 32;
    localparam int ADDR_W      = 8;
    localparam int CNT_W       = 9;
    localparam int PTR_W       = 10;
    localparam int LIST_DEPTH  = 256;
    localparam int INDEX_DEPTH = 256;
    localparam int PROD_W      = 41;
    localparam int DSH_W       = 40;
    localparam int Q_W         = 8;

    localparam logic [2:0] OP_WR_KEY   = 3'd0;
    localparam logic [2:0] OP_WR_INDEX = 3'd1;
    localparam logic [2:0] OP_SEQ      = 3'd2;
    localparam logic [2:0] OP_BIN      = 3'd3;
    localparam logic [2:0] OP_IDX      = 3'd4;
    localparam logic [2:0] OP_INT      = 3'd5;

    typedef struct packed {
        logic [2:0]               op;
        logic [ADDR_W-1:0]        slot;
        logic signed [KEY_W-1:0]  value;
        logic [ADDR_W-1:0]        entry_start;
        logic [ADDR_W-1:0]        range_low;
        logic [ADDR_W-1:0]        range_high;
        logic [CNT_W-1:0]         count;
    } req_t;

    typedef enum logic [4:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_SEQ_RD,
        ACT_SEQ_NEXT,
        ACT_BIN_RD,
        ACT_LO_UP,
        ACT_HI_DN,
        ACT_LO_MID,
        ACT_IDX_K0,
        ACT_IDX_KN,
        ACT_IDX_I0,
        ACT_IDX_PREV,
        ACT_IDX_RDN,
        ACT_IDX_RDL,
        ACT_IDX_NEXT,
        ACT_IDX_RDS,
        ACT_IDX_S0,
        ACT_IDX_S1,
        ACT_IDX_LAST,
        ACT_INT_RDH,
        ACT_INT_RDL,
        ACT_INT_MUL,
        ACT_INT_DIV,
        ACT_INT_RDJ,
        ACT_INT_RDF,
        ACT_HIT_LO,
        ACT_HIT_MID,
        ACT_MISS,
        ACT_EMIT
    } act_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SEQ_RD,
        ST_SEQ_CK,
        ST_BIN_RD,
        ST_BIN_CK,
        ST_IDX_K0,
        ST_IDX_CK0,
        ST_IDX_CKN,
        ST_IDX_I0,
        ST_IDX_LOOP,
        ST_IDX_CK,
        ST_IDX_S0,
        ST_IDX_S1,
        ST_IDX_LAST,
        ST_INT_RDH,
        ST_INT_RDL,
        ST_INT_CK,
        ST_INT_DIV,
        ST_INT_RDJ,
        ST_INT_CKJ,
        ST_INT_FIN,
        ST_INT_FCK,
        ST_OUT
    } state_t;

    typedef struct packed {
        act_t act;
    } cmd_t;

    typedef struct packed {
        logic lo_gt_hi;
        logic key_eq;
        logic key_gt;
        logic key_lt;
        logic n_zero;
        logic cnt_last;
        logic ivl_hit;
        logic int_go;
        logic div_last;
        logic lo_lt_n;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// ----- design/stse_ctrl.sv -----
`default_nettype none
`include "sorted_table_search_engine_macros.svh"
module stse_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    input  wire logic [2:0]       in_op,
    input  stse_pkg::status_t     status,
    output logic                  in_ready,
    output stse_pkg::cmd_t        cmd
);

    stse_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stse_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stse_pkg::ST_IDLE: begin
                if (in_valid) begin
                    priority case (in_op)
                        stse_pkg::OP_SEQ: state_next = stse_pkg::ST_SEQ_RD;
                        stse_pkg::OP_BIN: state_next = stse_pkg::ST_BIN_RD;
                        stse_pkg::OP_IDX: state_next = stse_pkg::ST_IDX_K0;
                        stse_pkg::OP_INT: state_next = stse_pkg::ST_INT_RDH;
                        default:          state_next = stse_pkg::ST_IDLE;
                    endcase
                end
            end
            stse_pkg::ST_SEQ_RD:
                state_next = status.lo_gt_hi ? stse_pkg::ST_OUT : stse_pkg::ST_SEQ_CK;
            stse_pkg::ST_SEQ_CK:
                state_next = status.key_eq ? stse_pkg::ST_OUT : stse_pkg::ST_SEQ_RD;
            stse_pkg::ST_BIN_RD:
                state_next = status.lo_gt_hi ? stse_pkg::ST_OUT : stse_pkg::ST_BIN_CK;
            stse_pkg::ST_BIN_CK:
                state_next = status.key_eq ? stse_pkg::ST_OUT : stse_pkg::ST_BIN_RD;
            stse_pkg::ST_IDX_K0:
                state_next = status.n_zero ? stse_pkg::ST_OUT : stse_pkg::ST_IDX_CK0;
            stse_pkg::ST_IDX_CK0:
                state_next = status.key_lt ? stse_pkg::ST_OUT : stse_pkg::ST_IDX_CKN;
            stse_pkg::ST_IDX_CKN:
                state_next = status.key_gt ? stse_pkg::ST_OUT : stse_pkg::ST_IDX_I0;
            stse_pkg::ST_IDX_I0:
                state_next = stse_pkg::ST_IDX_LOOP;
            stse_pkg::ST_IDX_LOOP:
                state_next = status.cnt_last ? stse_pkg::ST_IDX_LAST : stse_pkg::ST_IDX_CK;
            stse_pkg::ST_IDX_CK:
                state_next = status.ivl_hit ? stse_pkg::ST_IDX_S0 : stse_pkg::ST_IDX_LOOP;
            stse_pkg::ST_IDX_S0:
                state_next = stse_pkg::ST_IDX_S1;
            stse_pkg::ST_IDX_S1:
                state_next = stse_pkg::ST_SEQ_RD;
            stse_pkg::ST_IDX_LAST:
                state_next = stse_pkg::ST_SEQ_RD;
            stse_pkg::ST_INT_RDH:
                state_next = status.lo_gt_hi ? stse_pkg::ST_INT_FIN : stse_pkg::ST_INT_RDL;
            stse_pkg::ST_INT_RDL:
                state_next = stse_pkg::ST_INT_CK;
            stse_pkg::ST_INT_CK:
                state_next = status.int_go ? stse_pkg::ST_INT_DIV : stse_pkg::ST_INT_FIN;
            stse_pkg::ST_INT_DIV:
                state_next = status.div_last ? stse_pkg::ST_INT_RDJ : stse_pkg::ST_INT_DIV;
            stse_pkg::ST_INT_RDJ:
                state_next = stse_pkg::ST_INT_CKJ;
            stse_pkg::ST_INT_CKJ:
                state_next = stse_pkg::ST_INT_RDH;
            stse_pkg::ST_INT_FIN:
                state_next = status.lo_lt_n ? stse_pkg::ST_INT_FCK : stse_pkg::ST_OUT;
            stse_pkg::ST_INT_FCK:
                state_next = stse_pkg::ST_OUT;
            stse_pkg::ST_OUT:
                state_next = status.out_free ? stse_pkg::ST_IDLE : stse_pkg::ST_OUT;
            default:
                state_next = stse_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.act  = stse_pkg::ACT_NONE;
        in_ready = 1'b0;
        unique case (state_reg)
            stse_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.act = stse_pkg::ACT_LOAD;
                end
            end
            stse_pkg::ST_SEQ_RD:
                cmd.act = status.lo_gt_hi ? stse_pkg::ACT_MISS : stse_pkg::ACT_SEQ_RD;
            stse_pkg::ST_SEQ_CK:
                cmd.act = status.key_eq ? stse_pkg::ACT_HIT_LO : stse_pkg::ACT_SEQ_NEXT;
            stse_pkg::ST_BIN_RD:
                cmd.act = status.lo_gt_hi ? stse_pkg::ACT_MISS : stse_pkg::ACT_BIN_RD;
            stse_pkg::ST_BIN_CK: begin
                priority if (status.key_eq) begin
                    cmd.act = stse_pkg::ACT_HIT_MID;
                end else if (status.key_gt) begin
                    cmd.act = stse_pkg::ACT_LO_UP;
                end else begin
                    cmd.act = stse_pkg::ACT_HI_DN;
                end
            end
            stse_pkg::ST_IDX_K0:
                cmd.act = status.n_zero ? stse_pkg::ACT_MISS : stse_pkg::ACT_IDX_K0;
            stse_pkg::ST_IDX_CK0:
                cmd.act = status.key_lt ? stse_pkg::ACT_MISS : stse_pkg::ACT_IDX_KN;
            stse_pkg::ST_IDX_CKN:
                cmd.act = status.key_gt ? stse_pkg::ACT_MISS : stse_pkg::ACT_IDX_I0;
            stse_pkg::ST_IDX_I0:
                cmd.act = stse_pkg::ACT_IDX_PREV;
            stse_pkg::ST_IDX_LOOP:
                cmd.act = status.cnt_last ? stse_pkg::ACT_IDX_RDL : stse_pkg::ACT_IDX_RDN;
            stse_pkg::ST_IDX_CK:
                cmd.act = status.ivl_hit ? stse_pkg::ACT_IDX_RDS : stse_pkg::ACT_IDX_NEXT;
            stse_pkg::ST_IDX_S0:
                cmd.act = stse_pkg::ACT_IDX_S0;
            stse_pkg::ST_IDX_S1:
                cmd.act = stse_pkg::ACT_IDX_S1;
            stse_pkg::ST_IDX_LAST:
                cmd.act = stse_pkg::ACT_IDX_LAST;
            stse_pkg::ST_INT_RDH:
                cmd.act = status.lo_gt_hi ? stse_pkg::ACT_NONE : stse_pkg::ACT_INT_RDH;
            stse_pkg::ST_INT_RDL:
                cmd.act = stse_pkg::ACT_INT_RDL;
            stse_pkg::ST_INT_CK:
                cmd.act = status.int_go ? stse_pkg::ACT_INT_MUL : stse_pkg::ACT_NONE;
            stse_pkg::ST_INT_DIV:
                cmd.act = stse_pkg::ACT_INT_DIV;
            stse_pkg::ST_INT_RDJ:
                cmd.act = stse_pkg::ACT_INT_RDJ;
            stse_pkg::ST_INT_CKJ: begin
                priority if (status.key_gt) begin
                    cmd.act = stse_pkg::ACT_LO_UP;
                end else if (status.key_lt) begin
                    cmd.act = stse_pkg::ACT_HI_DN;
                end else begin
                    cmd.act = stse_pkg::ACT_LO_MID;
                end
            end
            stse_pkg::ST_INT_FIN:
                cmd.act = status.lo_lt_n ? stse_pkg::ACT_INT_RDF : stse_pkg::ACT_MISS;
            stse_pkg::ST_INT_FCK:
                cmd.act = status.key_eq ? stse_pkg::ACT_HIT_LO : stse_pkg::ACT_MISS;
            stse_pkg::ST_OUT:
                cmd.act = status.out_free ? stse_pkg::ACT_EMIT : stse_pkg::ACT_NONE;
            default:
                cmd.act = stse_pkg::ACT_NONE;
        endcase
    end

    `STSE_ASSERT(a_emit_free, aclk, aresetn, (cmd.act == stse_pkg::ACT_EMIT) |-> status.out_free)
    `STSE_ASSERT_NEXT(a_search_busy, aclk, aresetn,
        in_valid && in_ready && (in_op == stse_pkg::OP_SEQ || in_op == stse_pkg::OP_BIN ||
        in_op == stse_pkg::OP_IDX || in_op == stse_pkg::OP_INT), state_reg != stse_pkg::ST_IDLE)
    `STSE_ASSERT_NEXT(a_div_exit, aclk, aresetn,
        state_reg == stse_pkg::ST_INT_DIV && status.div_last, state_reg == stse_pkg::ST_INT_RDJ)

endmodule
`default_nettype wire

// ----- design/stse_datapath.sv -----
`default_nettype none
`include "sorted_table_search_engine_macros.svh"
module stse_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  stse_pkg::cmd_t                      cmd,
    input  stse_pkg::req_t                      req,
    input  wire logic                           cfg_valid,
    input  wire logic [stse_pkg::CNT_W-1:0]     cfg_data,
    input  wire logic                           m_ready,
    output stse_pkg::status_t                   status,
    output logic                                m_valid,
    output logic                                m_found,
    output logic [stse_pkg::ADDR_W-1:0]         m_position
);

    logic signed [stse_pkg::KEY_W-1:0]  key_mem  [stse_pkg::LIST_DEPTH];
    logic signed [stse_pkg::KEY_W-1:0]  ikey_mem [stse_pkg::INDEX_DEPTH];
    logic [stse_pkg::ADDR_W-1:0]        istart_mem [stse_pkg::INDEX_DEPTH];

    logic signed [stse_pkg::KEY_W-1:0]  key_q, ik_q;
    logic [stse_pkg::ADDR_W-1:0]        is_q;
    logic [stse_pkg::ADDR_W-1:0]        kaddr, iaddr;

    logic [stse_pkg::CNT_W-1:0]         entries_reg;
    logic signed [stse_pkg::KEY_W-1:0]  key_reg, prev_reg, khi_reg;
    logic signed [stse_pkg::PTR_W-1:0]  lo_reg, hi_reg, mid_reg;
    logic [stse_pkg::CNT_W-1:0]         n_reg, cnt_reg;
    logic [stse_pkg::PROD_W-1:0]        rem_reg;
    logic [stse_pkg::DSH_W-1:0]         dsh_reg;
    logic [stse_pkg::Q_W-1:0]           q_reg;
    logic [2:0]                         dcnt_reg;
    logic                               pend_found_reg;
    logic [stse_pkg::ADDR_W-1:0]        pend_pos_reg;
    logic                               m_valid_reg, m_found_reg;
    logic [stse_pkg::ADDR_W-1:0]        m_pos_reg;

    logic [stse_pkg::CNT_W-1:0]         n_clip;
    logic [stse_pkg::ADDR_W-1:0]        e_m1;
    logic signed [stse_pkg::PTR_W:0]    mid_sum;
    logic signed [stse_pkg::PTR_W-1:0]  mid_c, nm1, j_c, is_ext;
    logic signed [stse_pkg::KEY_W:0]    num, den;
    logic [stse_pkg::ADDR_W-1:0]        span;
    logic [stse_pkg::PROD_W-1:0]        prod;
    logic                               div_take;

    assign n_clip  = (req.count > stse_pkg::CNT_W'(stse_pkg::LIST_DEPTH))
                     ? stse_pkg::CNT_W'(stse_pkg::LIST_DEPTH) : req.count;
    assign e_m1    = (entries_reg == '0) ? '0 :
                     (entries_reg > stse_pkg::CNT_W'(stse_pkg::INDEX_DEPTH))
                     ? stse_pkg::ADDR_W'(stse_pkg::INDEX_DEPTH - 1)
                     : stse_pkg::ADDR_W'(entries_reg - 1'b1);
    assign mid_sum = {lo_reg[stse_pkg::PTR_W-1], lo_reg} + {hi_reg[stse_pkg::PTR_W-1], hi_reg};
    assign mid_c   = mid_sum[stse_pkg::PTR_W:1];
    assign nm1     = $signed({1'b0, n_reg}) - stse_pkg::PTR_W'(1);
    assign j_c     = lo_reg + $signed({2'b00, q_reg});
    assign is_ext  = $signed({2'b00, is_q});
    assign num     = {key_reg[stse_pkg::KEY_W-1], key_reg} - {key_q[stse_pkg::KEY_W-1], key_q};
    assign den     = {khi_reg[stse_pkg::KEY_W-1], khi_reg} - {key_q[stse_pkg::KEY_W-1], key_q};
    assign span    = stse_pkg::ADDR_W'(hi_reg - lo_reg);
    assign prod    = stse_pkg::PROD_W'($unsigned(num)) * stse_pkg::PROD_W'(span);
    assign div_take = ({1'b0, dsh_reg} <= rem_reg);

    always_comb begin
        kaddr = lo_reg[stse_pkg::ADDR_W-1:0];
        iaddr = cnt_reg[stse_pkg::ADDR_W-1:0];
        unique case (cmd.act)
            stse_pkg::ACT_BIN_RD:  kaddr = mid_c[stse_pkg::ADDR_W-1:0];
            stse_pkg::ACT_IDX_K0:  kaddr = '0;
            stse_pkg::ACT_IDX_KN:  kaddr = nm1[stse_pkg::ADDR_W-1:0];
            stse_pkg::ACT_INT_RDH: kaddr = hi_reg[stse_pkg::ADDR_W-1:0];
            stse_pkg::ACT_INT_RDJ: kaddr = j_c[stse_pkg::ADDR_W-1:0];
            stse_pkg::ACT_IDX_I0:  iaddr = '0;
            stse_pkg::ACT_IDX_RDN,
            stse_pkg::ACT_IDX_S0:  iaddr = stse_pkg::ADDR_W'(cnt_reg + 1'b1);
            stse_pkg::ACT_IDX_RDL: iaddr = e_m1;
            default: begin
                kaddr = lo_reg[stse_pkg::ADDR_W-1:0];
                iaddr = cnt_reg[stse_pkg::ADDR_W-1:0];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.act == stse_pkg::ACT_LOAD && req.op == stse_pkg::OP_WR_KEY) begin
            key_mem[req.slot] <= req.value;
        end
        key_q <= key_mem[kaddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.act == stse_pkg::ACT_LOAD && req.op == stse_pkg::OP_WR_INDEX) begin
            ikey_mem[req.slot]   <= req.value;
            istart_mem[req.slot] <= req.entry_start;
        end
        ik_q <= ikey_mem[iaddr];
        is_q <= istart_mem[iaddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= stse_pkg::CNT_W'(1);
        end else if (cfg_valid) begin
            entries_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.act)
            stse_pkg::ACT_LOAD: begin
                key_reg <= req.value;
                n_reg   <= n_clip;
                if (req.op == stse_pkg::OP_INT) begin
                    lo_reg <= '0;
                    hi_reg <= $signed({1'b0, n_clip}) - stse_pkg::PTR_W'(1);
                end else begin
                    lo_reg <= $signed({2'b00, req.range_low});
                    hi_reg <= $signed({2'b00, req.range_high});
                end
            end
            stse_pkg::ACT_SEQ_NEXT: lo_reg  <= lo_reg + stse_pkg::PTR_W'(1);
            stse_pkg::ACT_BIN_RD:   mid_reg <= mid_c;
            stse_pkg::ACT_LO_UP:    lo_reg  <= mid_reg + stse_pkg::PTR_W'(1);
            stse_pkg::ACT_HI_DN:    hi_reg  <= mid_reg - stse_pkg::PTR_W'(1);
            stse_pkg::ACT_LO_MID:   lo_reg  <= mid_reg;
            stse_pkg::ACT_IDX_I0:   cnt_reg <= '0;
            stse_pkg::ACT_IDX_PREV: prev_reg <= ik_q;
            stse_pkg::ACT_IDX_NEXT: begin
                prev_reg <= ik_q;
                cnt_reg  <= cnt_reg + 1'b1;
            end
            stse_pkg::ACT_IDX_S0:   lo_reg <= is_ext;
            stse_pkg::ACT_IDX_S1:   hi_reg <= (is_ext > nm1) ? nm1 : is_ext;
            stse_pkg::ACT_IDX_LAST: begin
                lo_reg <= is_ext;
                hi_reg <= nm1;
            end
            stse_pkg::ACT_INT_RDL:  khi_reg <= key_q;
            stse_pkg::ACT_INT_MUL: begin
                rem_reg  <= prod;
                dsh_reg  <= {den[stse_pkg::KEY_W:0], 7'b0};
                q_reg    <= '0;
                dcnt_reg <= 3'd7;
            end
            stse_pkg::ACT_INT_DIV: begin
                if (div_take) begin
                    rem_reg <= rem_reg - {1'b0, dsh_reg};
                end
                q_reg    <= {q_reg[stse_pkg::Q_W-2:0], div_take};
                dsh_reg  <= dsh_reg >> 1;
                dcnt_reg <= dcnt_reg - 3'd1;
            end
            stse_pkg::ACT_INT_RDJ:  mid_reg <= j_c;
            stse_pkg::ACT_HIT_LO: begin
                pend_found_reg <= 1'b1;
                pend_pos_reg   <= lo_reg[stse_pkg::ADDR_W-1:0];
            end
            stse_pkg::ACT_HIT_MID: begin
                pend_found_reg <= 1'b1;
                pend_pos_reg   <= mid_reg[stse_pkg::ADDR_W-1:0];
            end
            stse_pkg::ACT_MISS: begin
                pend_found_reg <= 1'b0;
                pend_pos_reg   <= '0;
            end
            default: begin
                lo_reg <= lo_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.act == stse_pkg::ACT_EMIT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.act == stse_pkg::ACT_EMIT) begin
            m_found_reg <= pend_found_reg;
            m_pos_reg   <= pend_pos_reg;
        end
    end

    assign status.lo_gt_hi = (lo_reg > hi_reg);
    assign status.key_eq   = (key_reg == key_q);
    assign status.key_gt   = (key_reg > key_q);
    assign status.key_lt   = (key_reg < key_q);
    assign status.n_zero   = (n_reg == '0);
    assign status.cnt_last = (cnt_reg >= {1'b0, e_m1});
    assign status.ivl_hit  = (prev_reg <= key_reg) && (ik_q > key_reg);
    assign status.int_go   = (khi_reg >= key_reg) && (key_reg > key_q);
    assign status.div_last = (dcnt_reg == '0);
    assign status.lo_lt_n  = (lo_reg < $signed({1'b0, n_reg}));
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid    = m_valid_reg;
    assign m_found    = m_found_reg;
    assign m_position = m_pos_reg;

    `STSE_ASSERT(a_div_operands, aclk, aresetn,
        (cmd.act == stse_pkg::ACT_INT_MUL) |-> (den > 0 && num > 0 && num <= den))
    `STSE_ASSERT(a_probe_in_range, aclk, aresetn,
        (cmd.act == stse_pkg::ACT_INT_RDJ) |-> (j_c >= lo_reg && j_c <= hi_reg))
    `STSE_ASSERT(a_miss_pos_zero, aclk, aresetn,
        (m_valid_reg && !m_found_reg) |-> (m_pos_reg == '0))
    `STSE_ASSERT_NEXT(a_emit_valid, aclk, aresetn,
        cmd.act == stse_pkg::ACT_EMIT, m_valid_reg)

endmodule
`default_nettype wire

// ----- design/sorted_table_search_engine.sv -----
// Channel   Direction  Handshake                 Payload
// s_        in         s_tvalid / s_tready       tuser: operation; tdata: request fields
// m_        out        m_tvalid / m_tready       tuser: found; tdata: position
// cfg_      in         cfg_valid / cfg_ready     cfg_data: index_entries
//
// One request at a time. Each key probe of a search reads the key memory, which has a
// registered read, and then compares: sequential and binary search probe until a hit or
// an empty range; indexed search checks the end keys, scans the index entries and then
// searches sequentially; interpolation computes each probe with a restoring divider.
// Reset clears control and sets index_entries to 1; tables are undefined until written.
// A result waits in the output register; the next request is taken once it has moved there.
`default_nettype none
module sorted_table_search_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // slot, value, entry_start, range_low, range_high, count
    input  wire logic [2:0]  s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // position
    output logic [0:0]       m_tuser,   // found
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_data
);

    stse_pkg::req_t    req;
    stse_pkg::cmd_t    cmd;
    stse_pkg::status_t status;
    logic              found;
    logic              unused_pad;

    assign req.op          = s_tuser;
    assign req.slot        = s_tdata[7:0];
    assign req.value       = $signed(s_tdata[39:8]);
    assign req.entry_start = s_tdata[47:40];
    assign req.range_low   = s_tdata[55:48];
    assign req.range_high  = s_tdata[63:56];
    assign req.count       = s_tdata[72:64];
    assign unused_pad      = ^s_tdata[79:73];

    assign cfg_ready = 1'b1;

    stse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    stse_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .req        (req),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .m_ready    (m_tready),
        .status     (status),
        .m_valid    (m_tvalid),
        .m_found    (found),
        .m_position (m_tdata)
    );

    assign m_tuser[0] = found;

endmodule
`default_nettype wire

// ----- sim/sorted_table_search_engine_tb.sv -----
`default_nettype none
module sorted_table_search_engine_tb;
    import stse_pkg::*;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam longint     KEY_MIN    = -64'sd2147483648;
    localparam longint     KEY_MAX    = 64'sd2147483647;
    localparam int         CYCLE_CAP  = 6000000;

    typedef struct {
        bit         found;
        logic [7:0] pos;
    } answer_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;

    sorted_table_search_engine u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic signed [31:0] key_tab [256];
    logic signed [31:0] ikey_tab [256];
    logic [7:0]         istart_tab [256];
    bit                 key_set [256];
    bit                 ientry_set [256];
    logic [8:0]         entries_reg;
    bit                 blank_read;

    answer_t     pending_answers [$];
    int          fail_count;
    int          search_count [8];
    int          cfg_count;
    int          cycle_count;
    bit          steady_tx;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("%0t timeout", $time);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic longint key_rd(input longint i);
        if (!key_set[i]) blank_read = 1'b1;
        return longint'(key_tab[i]);
    endfunction

    function automatic longint ikey_rd(input longint i);
        if (!ientry_set[i]) blank_read = 1'b1;
        return longint'(ikey_tab[i]);
    endfunction

    function automatic longint istart_rd(input longint i);
        if (!ientry_set[i]) blank_read = 1'b1;
        return longint'(istart_tab[i]);
    endfunction

    function automatic longint linear_find(input longint key, input longint lo,
                                           input longint hi);
        if (hi > 255) hi = 255;
        if (lo < 0) lo = 0;
        for (longint i = lo; i <= hi; i++)
            if (key_rd(i) == key) return i;
        return -1;
    endfunction

    function automatic longint halving_find(input longint key, input longint lo,
                                            input longint hi);
        longint mid;
        longint k;
        if (hi > 255) hi = 255;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            k = key_rd(mid);
            if (key == k) return mid;
            if (key > k) lo = mid + 1;
            else hi = mid - 1;
        end
        return -1;
    endfunction

    function automatic longint directory_find(input longint key, input longint n);
        longint e;
        longint i;
        longint lo;
        longint hi;
        e = entries_reg;
        if (n < 1) return -1;
        if (e < 1) e = 1;
        if (e > 256) e = 256;
        if (key < key_rd(0) || key > key_rd(n - 1)) return -1;
        for (i = 0; i < e - 1; i++)
            if (ikey_rd(i) <= key && ikey_rd(i + 1) > key) break;
        if (i >= e - 1) begin
            lo = istart_rd(e - 1);
            hi = n - 1;
        end else begin
            lo = istart_rd(i);
            hi = istart_rd(i + 1);
        end
        if (hi > n - 1) hi = n - 1;
        return linear_find(key, lo, hi);
    endfunction

    function automatic longint estimate_find(input longint key, input longint n);
        longint lo;
        longint hi;
        longint j;
        longint kj;
        lo = 0;
        if (n < 1) return -1;
        hi = n - 1;
        while (lo <= hi && key_rd(hi) >= key && key > key_rd(lo)) begin
            j = lo + ((key - key_rd(lo)) * (hi - lo)) / (key_rd(hi) - key_rd(lo));
            kj = key_rd(j);
            if (key > kj) lo = j + 1;
            else if (key < kj) hi = j - 1;
            else lo = j;
        end
        if (lo < n && key_rd(lo) == key) return lo;
        return -1;
    endfunction

    function automatic longint locate(input logic [2:0] op, input logic signed [31:0] value,
                                      input logic [7:0] rlo, input logic [7:0] rhi,
                                      input logic [8:0] cnt);
        longint n;
        n = (cnt > 256) ? 256 : cnt;
        blank_read = 1'b0;
        case (op)
            OP_SEQ:  return linear_find(value, rlo, rhi);
            OP_BIN:  return halving_find(value, rlo, rhi);
            OP_IDX:  return directory_find(value, n);
            OP_INT:  return estimate_find(value, n);
            default: return -1;
        endcase
    endfunction

    task automatic idle_gap();
        int r;
        int g;
        r = $urandom_range(0, 99);
        g = steady_tx ? 0 : (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 40);
        @(negedge aclk);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
    endtask

    task automatic send_request(input logic [2:0] op, input logic [7:0] slot,
                                input logic signed [31:0] value, input logic [7:0] estart,
                                input logic [7:0] rlo, input logic [7:0] rhi,
                                input logic [8:0] cnt);
        longint  hit;
        answer_t a;
        idle_gap();
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, cnt, rhi, rlo, estart, value, slot};
        do @(posedge aclk); while (!s_tready);
        case (op)
            OP_WR_KEY: begin
                key_tab[slot] = value;
                key_set[slot] = 1'b1;
            end
            OP_WR_INDEX: begin
                ikey_tab[slot]   = value;
                istart_tab[slot] = estart;
                ientry_set[slot] = 1'b1;
            end
            OP_SEQ, OP_BIN, OP_IDX, OP_INT: begin
                hit = locate(op, value, rlo, rhi, cnt);
                a.found = (hit >= 0);
                a.pos   = (hit >= 0) ? hit[7:0] : 8'd0;
                pending_answers.push_back(a);
                search_count[op]++;
            end
            default: ;
        endcase
    endtask

    task automatic write_key(input logic [7:0] slot, input longint v);
        send_request(OP_WR_KEY, slot, v[31:0], $urandom, $urandom, $urandom, $urandom);
    endtask

    // search; one that would read an unwritten table entry is sent as a sequential search of slots 0 to 255
    task automatic search(input logic [2:0] op, input logic signed [31:0] value,
                          input logic [7:0] rlo, input logic [7:0] rhi, input logic [8:0] cnt);
        longint hit;
        hit = locate(op, value, rlo, rhi, cnt);
        if (blank_read) begin
            op = OP_SEQ;
            rlo = 8'd0;
            rhi = 8'd255;
        end
        send_request(op, $urandom, value, $urandom, rlo, rhi, cnt);
    endtask

    task automatic drain();
        idle_gap();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic set_entries(input logic [8:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        entries_reg = v;
        cfg_count++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic longint table_key();
        return longint'(key_tab[$urandom_range(0, 255)]);
    endfunction

    function automatic longint pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return table_key();
        if (r < 9) return table_key() + $urandom_range(0, 2) - 1;
        return longint'($signed($urandom));
    endfunction

    task automatic load_sorted(input int first, input int last);
        longint v;
        longint step;
        v = (first == 0) ? KEY_MIN : longint'(key_tab[first - 1]);
        step = ($urandom_range(0, 3) == 0) ? 2 : longint'($urandom_range(1, 24000000));
        for (int s = first; s <= last; s++) begin
            if (s > first || first > 0) v = v + $urandom_range(0, 1) * step
                                              + $urandom_range(0, 3);
            if (v > KEY_MAX || s == 255) v = KEY_MAX;
            write_key(s[7:0], v);
        end
    endtask

    task automatic test_table_load();
        load_sorted(0, 255);
        for (int i = 0; i < 16; i++)
            send_request(OP_WR_INDEX, i[7:0], key_tab[16 * i], 8'(16 * i),
                         $urandom, $urandom, $urandom);
    endtask

    task automatic test_directed();
        search(OP_SEQ, key_tab[0], 8'd0, 8'd255, 9'd1);
        search(OP_SEQ, key_tab[255], 8'd0, 8'd255, 9'd1);
        search(OP_SEQ, key_tab[40], 8'd41, 8'd40, 9'd1);
        search(OP_SEQ, key_tab[40], 8'd40, 8'd40, 9'd1);
        search(OP_BIN, key_tab[0], 8'd0, 8'd255, 9'd1);
        search(OP_BIN, key_tab[255], 8'd0, 8'd255, 9'd1);
        search(OP_BIN, key_tab[100] + 1, 8'd0, 8'd255, 9'd1);
        search(OP_BIN, key_tab[9], 8'd200, 8'd10, 9'd1);
        search(OP_IDX, key_tab[0], 8'd0, 8'd0, 9'd256);
        search(OP_IDX, key_tab[30], 8'd0, 8'd0, 9'd0);
        search(OP_IDX, key_tab[200], 8'd0, 8'd0, 9'd511);
        search(OP_IDX, key_tab[200], 8'd0, 8'd0, 9'd100);
        search(OP_INT, key_tab[0], 8'd0, 8'd0, 9'd256);
        search(OP_INT, key_tab[255], 8'd0, 8'd0, 9'd511);
        search(OP_INT, key_tab[77], 8'd0, 8'd0, 9'd256);
        search(OP_INT, key_tab[77], 8'd0, 8'd0, 9'd0);
        search(OP_INT, key_tab[77] + 1, 8'd0, 8'd0, 9'd200);
        send_request(OP_SPARE_6, 8'hff, 32'hffffffff, 8'hff, 8'hff, 8'hff, 9'h1ff);
        send_request(OP_SPARE_7, 8'h00, 32'h0, 8'h0, 8'h0, 8'h0, 9'h0);
        search(OP_SEQ, 32'sh80000000, 8'd0, 8'd255, 9'd1);
        search(OP_SEQ, 32'sh7fffffff, 8'd255, 8'd255, 9'd1);
    endtask

    task automatic random_search();
        logic [2:0] op;
        logic [7:0] a;
        logic [7:0] b;
        op = 3'(OP_SEQ + $urandom_range(0, 3));
        a = $urandom;
        b = $urandom;
        if ($urandom_range(0, 3) != 0 && a > b) {a, b} = {b, a};
        search(op, pick_key(), a, b,
               ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(1, 256)));
    endtask

    task automatic test_entries_sweep();
        logic [8:0] levels [5] = '{9'd1, 9'd16, 9'd0, 9'd256, 9'd511};
        foreach (levels[k]) begin
            set_entries(levels[k]);
            for (int i = 0; i < 15; i++)
                search(OP_IDX, pick_key(), $urandom, $urandom, 9'($urandom_range(1, 256)));
        end
        set_entries(9'd16);
    endtask

    task automatic test_random();
        int     r;
        int     s;
        longint lo;
        longint hi;
        for (int i = 0; i < 450; i++) begin
            if (i % 90 == 0) steady_tx = ($urandom_range(0, 2) == 0);
            if (i == 225) drain();
            r = $urandom_range(0, 99);
            if (r < 72) random_search();
            else if (r < 84) begin
                // keep order: new key between the neighbours
                s  = $urandom_range(0, 255);
                lo = (s == 0) ? KEY_MIN : longint'(key_tab[s - 1]);
                hi = (s == 255) ? KEY_MAX : longint'(key_tab[s + 1]);
                if (hi < lo) hi = lo;
                write_key(s[7:0], lo + longint'({$urandom, $urandom} % (hi - lo + 1)));
            end else if (r < 90) begin
                s = $urandom_range(0, 15);
                send_request(OP_WR_INDEX, s[7:0], key_tab[16 * s + $urandom_range(0, 3)],
                             8'(16 * s + $urandom_range(0, 3)), $urandom, $urandom, $urandom);
            end else if (r < 93) begin
                s = $urandom_range(1, 250);
                load_sorted(s, s + $urandom_range(0, 5));
            end else if (r < 96)
                send_request(OP_WR_INDEX, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom);
            else if (r < 98)
                write_key($urandom, longint'($signed($urandom)));
            else
                send_request($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7, $urandom,
                             $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        steady_tx = 1'b0;
    endtask

    // receiver stalls
    initial begin
        int r;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            r = $urandom_range(0, 99);
            @(negedge aclk);
            if (r < 10) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(30, 80)) @(negedge aclk);
            end else if (r < 60)
                m_tready <= 1'b1;
            else begin
                m_tready <= 1'b0;
                repeat ((r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40))
                    @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        answer_t a;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t unexpected result: found %0d position %0d",
                         $time, m_tuser, m_tdata);
                fail_count++;
            end else begin
                a = pending_answers.pop_front();
                if (m_tuser[0] !== a.found) begin
                    $display("%0t found: expected %0d actual %0d", $time, a.found, m_tuser);
                    fail_count++;
                end
                if (m_tdata !== a.pos) begin
                    $display("%0t position: expected %0d actual %0d", $time, a.pos, m_tdata);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        entries_reg = 9'd1;
        fail_count  = 0;
        cfg_count   = 0;
        cycle_count = 0;
        steady_tx   = 1'b0;
        for (int i = 0; i < 256; i++) begin
            key_set[i]    = 1'b0;
            ientry_set[i] = 1'b0;
        end
        foreach (search_count[i]) search_count[i] = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_table_load();
        test_directed();
        test_entries_sweep();
        test_random();
        drain();
        repeat (50) @(negedge aclk);
        if (pending_answers.size() != 0) begin
            $display("%0t %0d results never arrived", $time, pending_answers.size());
            fail_count++;
        end

        $display("searches: sequential %0d, binary %0d, indexed %0d, interpolation %0d",
                 search_count[OP_SEQ], search_count[OP_BIN], search_count[OP_IDX],
                 search_count[OP_INT]);
        $display("index entry settings applied: %0d, mismatches: %0d", cfg_count, fail_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
+incdir+design
design/stse_pkg.sv
design/stse_ctrl.sv
design/stse_datapath.sv
design/sorted_table_search_engine.sv
sim/sorted_table_search_engine_tb.sv
